[hw/rtl/svia_pkg.sv]
// ----------------------------------------------------------------------------
// svia_pkg: shared types and codes of the integer ALU
// Operation codes and the command/status structs between controller and
// datapath.
// ----------------------------------------------------------------------------
package svia_pkg;

  localparam int unsigned FIELD_BITS = 64;
  localparam int unsigned MODE_BITS  = 4;

  typedef logic [MODE_BITS-1:0] mode_t;

  localparam mode_t OP_ADD   = 4'd0;
  localparam mode_t OP_SUB   = 4'd1;
  localparam mode_t OP_MUL   = 4'd2;
  localparam mode_t OP_POW   = 4'd3;
  localparam mode_t OP_DIV   = 4'd4;
  localparam mode_t OP_FDIV  = 4'd5;
  localparam mode_t OP_MOD   = 4'd6;
  localparam mode_t OP_AND   = 4'd7;
  localparam mode_t OP_OR    = 4'd8;
  localparam mode_t OP_XOR   = 4'd9;
  localparam mode_t OP_SHL   = 4'd10;
  localparam mode_t OP_SHR   = 4'd11;
  localparam mode_t OP_EQ    = 4'd12;
  localparam mode_t OP_LT    = 4'd13;
  localparam mode_t OP_LE    = 4'd14;
  localparam mode_t OP_NEG   = 4'd15;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture operands, set up iteration
    logic step;     // run one iteration step
    logic finish;   // form result into output register
  } svia_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic iter;     // loaded mode needs iteration
    logic last;     // current step is the last one
  } svia_sts_t;

endpackage

[hw/rtl/svia_if.sv]
// ----------------------------------------------------------------------------
// svia_in_if / svia_out_if: valid-ready channels of the integer ALU
// Input word carries mode and operands; output word carries the result.
// ----------------------------------------------------------------------------
interface svia_in_if;
  logic                   valid;
  logic                   ready;
  svia_pkg::mode_t        mode;
  logic signed [63:0]     left_operand;
  logic signed [63:0]     right_operand;
  modport source (output valid, mode, left_operand, right_operand, input ready);
  modport sink   (input valid, mode, left_operand, right_operand, output ready);
endinterface

interface svia_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               truth;
  logic               error;
  modport source (output valid, value, truth, error, input ready);
  modport sink   (input valid, value, truth, error, output ready);
endinterface

[hw/rtl/svia_ctrl.sv]
// ----------------------------------------------------------------------------
// svia_ctrl: controller of the integer ALU
// Sequences load, iteration steps and result hand-off.
// ----------------------------------------------------------------------------
module svia_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  svia_pkg::svia_sts_t sts,
  output svia_pkg::svia_cmd_t cmd
);
  import svia_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       out_free;

  // output register frees when empty or being taken
  assign out_free  = !ovld_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt  = state_r;
    ovld_nxt   = ovld_r;
    cmd        = '0;
    if (ovld_r && out_ready) ovld_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.iter && !sts.last) begin
          cmd.step = 1'b1;
        end else begin
          if (sts.iter) cmd.step = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          ovld_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

[hw/rtl/svia_dp.sv]
// ----------------------------------------------------------------------------
// svia_dp: datapath of the integer ALU
// One-step operations, a radix-2 multiplier, bit-serial passes for power and
// a restoring divider; multiply and divide share one iteration counter.
// ----------------------------------------------------------------------------
module svia_dp #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk,
  input  svia_pkg::mode_t      mode,
  input  logic signed [63:0]   left_operand,
  input  logic signed [63:0]   right_operand,
  input  svia_pkg::svia_cmd_t  cmd,
  output svia_pkg::svia_sts_t  sts,
  output logic signed [63:0]   value,
  output logic                 truth,
  output logic                 error
);
  import svia_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned CW = $clog2(W + 1);

  typedef logic [W-1:0] word_t;

  // operand and iteration registers
  mode_t      mode_r;
  word_t      a_r, b_r;
  word_t      acc_r;      // product / power result / quotient
  word_t      base_r;     // multiplicand / power base
  word_t      exp_r;      // multiplier bits / exponent bits / dividend bits
  word_t      rem_r;      // divider partial remainder
  logic       mulph_r;    // power: 0 = multiply phase, 1 = square phase
  logic [CW-1:0] cnt_r;
  word_t      sq_r;       // product accumulator of the power multiply and square passes
  word_t      sqm_r;      // declared but not used
  logic [CW-1:0] scnt_r;

  logic signed [63:0] val_r;
  logic       tru_r, err_r;

  word_t a_w, b_w;
  assign a_w = left_operand[W-1:0];
  assign b_w = right_operand[W-1:0];

  logic sa, sb;
  word_t ma, mb;
  assign sa = a_r[W-1];
  assign sb = b_r[W-1];
  assign ma = sa ? (~a_r + word_t'(1)) : a_r;
  assign mb = sb ? (~b_r + word_t'(1)) : b_r;

  logic is_div, is_mul, is_pow;
  assign is_mul = (mode_r == OP_MUL);
  assign is_pow = (mode_r == OP_POW);
  assign is_div = (mode_r == OP_DIV) || (mode_r == OP_FDIV) || (mode_r == OP_MOD);

  // power: per exponent bit, a multiply pass (if bit set), then a square pass;
  // W shift-add steps each; ends at a zero exponent or the top bit's square pass.
  always_comb begin
    sts.iter = is_mul || (is_pow && !b_r[W-1]) || (is_div && (b_r != '0));
    if (is_pow) sts.last = (exp_r == '0) || (exp_r == word_t'(1) && mulph_r
                            && scnt_r == CW'(1));
    else        sts.last = (cnt_r == CW'(1));
  end

  // divider step, compared against the divisor magnitude
  word_t rem_sh, rem_sub;
  logic  rem_ge;
  logic [W:0] rem_w;
  always_comb begin
    rem_w   = {rem_r, exp_r[W-1]};
    rem_ge  = rem_w >= {1'b0, mb};
    rem_sub = W'(rem_w - {1'b0, mb});
    rem_sh  = rem_w[W-1:0];
  end

  // final result forming
  word_t qm, rm, q, r, res_w;
  logic  eq_c, lt_c, gt_c;
  logic [63:0] amt_m;
  logic        amt_neg, go_left, big;
  logic [$clog2(W)-1:0] sh;
  always_comb begin
    qm = acc_r;
    rm = rem_r;
    q  = (sa != sb) ? (~qm + word_t'(1)) : qm;
    r  = sa ? (~rm + word_t'(1)) : rm;
    if (mode_r == OP_FDIV && rm != '0 && sa != sb) q = q - word_t'(1);
    eq_c = (a_r == b_r);
    lt_c = $signed(a_r) < $signed(b_r);
    gt_c = $signed(b_r) < $signed(a_r);
    amt_neg = b_r[W-1];
    amt_m   = 64'(mb);
    go_left = (mode_r == OP_SHL) ^ amt_neg;
    big     = amt_m >= 64'(W);
    sh      = amt_m[$clog2(W)-1:0];
    res_w   = '0;
    case (mode_r)
      OP_ADD:  res_w = a_r + b_r;
      OP_SUB:  res_w = a_r - b_r;
      OP_MUL:  res_w = acc_r;
      OP_POW:  res_w = b_r[W-1] ? word_t'(1) : acc_r;
      OP_DIV, OP_FDIV: res_w = (b_r == '0) ? '0 : q;
      OP_MOD:  res_w = (b_r == '0) ? '0 : r;
      OP_AND:  res_w = a_r & b_r;
      OP_OR:   res_w = a_r | b_r;
      OP_XOR:  res_w = a_r ^ b_r;
      OP_SHL, OP_SHR: begin
        if (go_left) res_w = big ? '0 : (a_r << sh);
        else         res_w = big ? {W{sa}} : word_t'($signed(a_r) >>> sh);
      end
      OP_NEG:  res_w = ~a_r + word_t'(1);
      default: res_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode;
      a_r     <= a_w;
      b_r     <= b_w;
      mulph_r <= 1'b0;
      cnt_r   <= CW'(W);
      scnt_r  <= CW'(W);
      rem_r   <= '0;
      sq_r    <= '0;
      unique case (mode)
        OP_MUL: begin
          acc_r  <= '0;
          base_r <= a_w;
          exp_r  <= b_w;
        end
        OP_POW: begin
          acc_r  <= word_t'(1);
          base_r <= a_w;
          exp_r  <= b_w;
        end
        default: begin
          // divider: dividend magnitude shifts in from the top, quotient in acc
          acc_r  <= '0;
          base_r <= '0;
          exp_r  <= a_w[W-1] ? (~a_w + word_t'(1)) : a_w;
        end
      endcase
      if (b_w[W-1] && (mode == OP_DIV || mode == OP_FDIV || mode == OP_MOD))
        b_r <= b_w;
    end else if (cmd.step) begin
      if (is_mul) begin
        // shift-add: one multiplier bit per step
        if (exp_r[0]) acc_r <= acc_r + base_r;
        base_r <= base_r << 1;
        exp_r  <= exp_r >> 1;
        cnt_r  <= cnt_r - CW'(1);
      end else if (is_pow) begin
        if (!mulph_r) begin
          // multiply pass: acc *= base when exponent bit set, bit-serial
          if (exp_r[0]) begin
            if (cnt_r != '0) begin
              if (base_r[W - int'(cnt_r)]) sq_r <= sq_r + (acc_r << (W - int'(cnt_r)));
              cnt_r <= cnt_r - CW'(1);
            end else begin
              acc_r   <= sq_r;
              sq_r    <= '0;
              mulph_r <= 1'b1;
            end
          end else begin
            mulph_r <= 1'b1;
          end
        end else begin
          // square pass: base *= base, bit-serial
          if (scnt_r != '0) begin
            if (base_r[W - int'(scnt_r)])
              sq_r <= sq_r + (base_r << (W - int'(scnt_r)));
            scnt_r <= scnt_r - CW'(1);
          end else begin
            base_r  <= sq_r;
            sq_r    <= '0;
            exp_r   <= exp_r >> 1;
            mulph_r <= 1'b0;
            cnt_r   <= CW'(W);
            scnt_r  <= CW'(W);
          end
        end
      end else begin
        // restoring division, one quotient bit per step on magnitudes
        rem_r <= rem_ge ? rem_sub : rem_sh;
        acc_r <= {acc_r[W-2:0], rem_ge};
        exp_r <= exp_r << 1;
        cnt_r <= cnt_r - CW'(1);
      end
    end
    if (cmd.finish) begin
      val_r <= 64'($signed(res_w));
      tru_r <= (mode_r == OP_EQ) ? eq_c : (mode_r == OP_LT) ? lt_c :
               (mode_r == OP_LE) ? !gt_c : 1'b0;
      err_r <= is_div && (b_r == '0);
    end
  end

  assign value = val_r;
  assign truth = tru_r;
  assign error = err_r;

endmodule

[hw/rtl/script_vm_integer_alu_unit.sv]
// ----------------------------------------------------------------------------
// script_vm_integer_alu_unit: integer ALU of a script interpreter
// Controller and datapath joined by command and status structs.
//
//  channel | dir | payload
//  in_     | in  | mode, left_operand, right_operand
//  out_    | out | value, truth, error
//
// Simple operations, a zero divisor and a negative exponent take no iteration
// steps; multiply and divide take W one-bit steps. Power takes a multiply
// pass of W shift-add steps and a commit step per set exponent bit, one step
// per clear bit, and a square pass of W steps and a commit step per bit (no
// commit for the top one), so a 63-bit exponent sets the worst case.
// One word is computed at a time; in_ready is high only when idle.
// rst_n is synchronous; the output register holds while out_ready is low.
// ----------------------------------------------------------------------------
module script_vm_integer_alu_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input logic    clk,
  input logic    rst_n,
  svia_in_if.sink    in_ch,
  svia_out_if.source out_ch
);
  import svia_pkg::*;

  svia_cmd_t cmd;
  svia_sts_t sts;

  svia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svia_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk          (clk),
    .mode         (in_ch.mode),
    .left_operand (in_ch.left_operand),
    .right_operand(in_ch.right_operand),
    .cmd          (cmd),
    .sts          (sts),
    .value        (out_ch.value),
    .truth        (out_ch.truth),
    .error        (out_ch.error)
  );

endmodule

[bench/script_vm_integer_alu_unit_test.sv]
// ----------------------------------------------------------------------------
// script_vm_integer_alu_unit_test: testbench of the script VM integer ALU
// Sends mode/operand words through the input channel and compares each
// result word with a predicted one. Runs a directed pass over the corner
// cases and then random words under several idle and stall phases, with a
// long receiver hold and a full drain pause in between.
// ----------------------------------------------------------------------------
module script_vm_integer_alu_unit_test;
  import svia_pkg::*;

  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0] value;
    logic        truth;
    logic        error;
  } alu_result_t;

  logic clk;
  logic rst_n;

  svia_in_if  in_ch ();
  svia_out_if out_ch ();

  script_vm_integer_alu_unit #(.WORD_BITS(64)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_result_t pending_results[$];
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_request;
  int unsigned hold_left;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] abs_of(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // Shift with the direction reversed by a negative amount
  function automatic logic [63:0] shift_by(logic [63:0] x, logic [63:0] amt,
                                           logic go_left);
    logic [63:0] n;
    logic        left;
    n    = abs_of(amt);
    left = amt[63] ? !go_left : go_left;
    if (left) begin
      return (n >= 64) ? 64'd0 : (x << n[5:0]);
    end
    if (n >= 64) begin
      return x[63] ? ALL_ONES : 64'd0;
    end
    return $signed(x) >>> n[5:0];
  endfunction

  function automatic logic [63:0] power_of_word(logic [63:0] base, logic [63:0] expo);
    logic [63:0] acc;
    acc = 64'd1;
    if (expo[63]) begin
      return 64'd1;
    end
    while (expo != 0) begin
      if (expo[0]) begin
        acc = acc * base;
      end
      base = base * base;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  // Predict one result word
  function automatic alu_result_t alu_predict(mode_t m, logic [63:0] a, logic [63:0] b);
    alu_result_t r;
    logic [63:0] qm;
    logic [63:0] rm;
    logic [63:0] q;
    r.value = 64'd0;
    r.truth = 1'b0;
    r.error = 1'b0;
    case (m)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_POW: r.value = power_of_word(a, b);
      OP_DIV, OP_FDIV, OP_MOD: begin
        if (b == 0) begin
          r.error = 1'b1;
        end else begin
          qm = abs_of(a) / abs_of(b);
          rm = abs_of(a) % abs_of(b);
          q  = (a[63] != b[63]) ? (64'd0 - qm) : qm;
          if (m == OP_MOD) begin
            r.value = a[63] ? (64'd0 - rm) : rm;
          end else begin
            if (m == OP_FDIV && rm != 0 && a[63] != b[63]) begin
              q = q - 64'd1;
            end
            r.value = q;
          end
        end
      end
      OP_AND: r.value = a & b;
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_SHL: r.value = shift_by(a, b, 1'b1);
      OP_SHR: r.value = shift_by(a, b, 1'b0);
      OP_EQ:  r.truth = (a == b);
      OP_LT:  r.truth = ($signed(a) < $signed(b));
      OP_LE:  r.truth = ($signed(a) <= $signed(b));
      default: r.value = 64'd0 - a;
    endcase
    return r;
  endfunction

  // Send one word; valid stays high for a back-to-back follower
  task automatic send_word(mode_t m, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= m;
    in_ch.left_operand  <= a;
    in_ch.right_operand <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(alu_predict(m, a, b));
  endtask

  // Check accepted result words and drive out ready
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h truth=%b error=%b", $time,
                 out_ch.value, out_ch.truth, out_ch.error);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.value !== exp_r.value) begin
          $display("%0t: value expected %h actual %h", $time, exp_r.value, out_ch.value);
          fail_count++;
        end
        if (out_ch.truth !== exp_r.truth) begin
          $display("%0t: truth expected %b actual %b", $time, exp_r.truth, out_ch.truth);
          fail_count++;
        end
        if (out_ch.error !== exp_r.error) begin
          $display("%0t: error expected %b actual %b", $time, exp_r.error, out_ch.error);
          fail_count++;
        end
      end
    end
    // Long hold takes priority over random stalls
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Operand biased toward the extremes
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return MOST_NEG;
      2: return MOST_POS;
      3: return ALL_ONES;
      4: return 64'd1;
      5: return 64'($signed($urandom_range(200)) - 100);
      default: return rand_word();
    endcase
  endfunction

  // Right operand shaped by mode so shifts and power stay interesting
  function automatic logic [63:0] rand_right(mode_t m);
    if (m == OP_SHL || m == OP_SHR) begin
      if ($urandom_range(9) == 0) begin
        return rand_operand();
      end
      return 64'($signed($urandom_range(160)) - 80);
    end
    if (m == OP_POW) begin
      case ($urandom_range(29))
        0: return rand_word() >> 1;
        1, 2: return {1'b1, 63'($urandom())};
        default: return 64'($urandom_range(20));
      endcase
    end
    return rand_operand();
  endfunction

  task automatic test_directed();
    send_word(OP_ADD, MOST_POS, 64'd1);
    send_word(OP_SUB, MOST_NEG, 64'd1);
    send_word(OP_MUL, MOST_POS, MOST_POS);
    send_word(OP_POW, 64'd3, 64'd5);
    send_word(OP_POW, 64'd7, ALL_ONES);
    send_word(OP_POW, MOST_NEG, 64'd0);
    send_word(OP_DIV, 64'd5, 64'd0);
    send_word(OP_FDIV, MOST_NEG, 64'd0);
    send_word(OP_MOD, ALL_ONES, 64'd0);
    send_word(OP_DIV, MOST_NEG, ALL_ONES);
    send_word(OP_FDIV, MOST_NEG, ALL_ONES);
    send_word(OP_MOD, MOST_NEG, ALL_ONES);
    send_word(OP_FDIV, -64'sd7, 64'd2);
    send_word(OP_FDIV, 64'd7, -64'sd2);
    send_word(OP_MOD, -64'sd7, 64'd2);
    send_word(OP_AND, MOST_NEG, ALL_ONES);
    send_word(OP_OR, MOST_POS, MOST_NEG);
    send_word(OP_XOR, ALL_ONES, MOST_POS);
    send_word(OP_SHL, 64'h1234_5678_9ABC_DEF0, -64'sd4);
    send_word(OP_SHL, 64'd1, 64'd64);
    send_word(OP_SHR, MOST_NEG, 64'd64);
    send_word(OP_SHR, MOST_NEG, MOST_NEG);
    send_word(OP_EQ, MOST_NEG, MOST_NEG);
    send_word(OP_LT, MOST_NEG, MOST_POS);
    send_word(OP_LE, ALL_ONES, ALL_ONES);
    send_word(OP_NEG, MOST_NEG, 64'd0);
  endtask

  task automatic test_random(int unsigned count, int unsigned idle_pct,
                             int unsigned stall_pct);
    mode_t m;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      m = mode_t'($urandom_range(15));
      send_word(m, rand_operand(), rand_right(m));
    end
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 400;
    repeat (20) send_word(OP_ADD, rand_word(), rand_word());
  endtask

  // Sender pauses until every result has come back
  task automatic test_drain_pause();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) send_word(OP_MUL, rand_word(), rand_word());
  endtask

  initial begin
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = OP_ADD;
    in_ch.left_operand  = 64'd0;
    in_ch.right_operand = 64'd0;
    out_ch.ready        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(225, 0, 0);
    test_backpressure();
    test_random(225, 52, 0);
    test_drain_pause();
    test_random(225, 0, 52);
    test_random(225, 8, 8);

    // Drain and let the block settle
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/svia_pkg.sv
hw/rtl/svia_if.sv
hw/rtl/svia_ctrl.sv
hw/rtl/svia_dp.sv
hw/rtl/script_vm_integer_alu_unit.sv
bench/script_vm_integer_alu_unit_test.sv
